>>> rtl/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg: shared types and constants for the multipath link selector
// Channel count, field widths, mode and register codes, the token that walks
// the cell chain, and the fraction table for the per-period byte limit.
// ----------------------------------------------------------------------------
package mls_pkg;

    // Channel chain and map geometry
    localparam int NUM_CHAN  = 4;
    localparam int MAP_SLOTS = 4;
    localparam int SLOT_LIM  = (NUM_CHAN < MAP_SLOTS) ? NUM_CHAN : MAP_SLOTS;
    localparam int CH_W      = 2;      // chosen_channel width
    localparam int CNT_W     = 3;      // channels_in_use width

    // Field and state widths
    localparam int NODE_W   = 8;
    localparam int BYTES_W  = 16;
    localparam int CAP_W    = 16;
    localparam int KB_W     = 24;
    localparam int RATE_W   = 21;
    localparam int LIM_W    = 20;      // capacity * 64 / 5 fits in 20 bits
    localparam int VAL_W    = 20;      // ranking value, max of rate and kbyte spare
    localparam int KB_ADD_W = BYTES_W - 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Balance modes
    localparam logic [1:0] BAL_FIRST = 2'd0;
    localparam logic [1:0] BAL_RATE  = 2'd1;
    localparam logic [1:0] BAL_BYTES = 2'd2;

    // Drop modes
    localparam logic [1:0] DROP_NEVER = 2'd0;
    localparam logic [1:0] DROP_RATE  = 2'd1;
    localparam logic [1:0] DROP_BYTES = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DROP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP  = 3'd3;
    localparam int                   REG_CAP0 = 4;

    // Per-packet context broadcast to every cell
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [1:0]        bmode;
        logic [CNT_W-1:0]  nlim;
    } t_ctx;

    // Running choice handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [CH_W-1:0]   best;
        logic [VAL_W-1:0]  best_val;
        logic [CAP_W-1:0]  best_sr;
        logic [LIM_W-1:0]  best_sk;
    } t_tok;

    // Counter update for the chosen channel
    typedef struct packed {
        logic                vld;
        logic [CH_W-1:0]     sel;
        logic [KB_ADD_W-1:0] kb;
    } t_upd;

    // floor(64 * r / 5) for remainder r of capacity / 5
    function automatic logic [5:0] limit_frac(input logic [2:0] rem);
        logic [5:0] f;
        case (rem)
            3'd0:    f = 6'd0;
            3'd1:    f = 6'd12;
            3'd2:    f = 6'd25;
            3'd3:    f = 6'd38;
            3'd4:    f = 6'd51;
            default: f = 6'd0;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/mls_cell.sv
// ----------------------------------------------------------------------------
// mls_cell: one channel slot of the selector chain
// Holds the slot's capacity, byte limit, period kbyte counter and measured
// rate. Compares itself against the incoming token and registers the token.
// ----------------------------------------------------------------------------
module mls_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mls_pkg::CH_W-1:0]  i_index,
    input  logic [mls_pkg::NODE_W-1:0] i_node_id,
    input  logic                      i_cap_we,
    input  logic [mls_pkg::CAP_W-1:0] i_cap_data,
    input  mls_pkg::t_ctx             i_ctx,
    input  logic                      i_tick,
    input  mls_pkg::t_upd             i_upd,
    input  mls_pkg::t_tok             i_tok,
    input  logic                      i_tok_vld,
    output mls_pkg::t_tok             o_tok,
    output logic                      o_tok_vld
);
    import mls_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    logic [LIM_W-1:0]  r_limit;
    logic [KB_W-1:0]   r_kb;
    logic [RATE_W-1:0] r_rate;
    t_tok              r_tok;
    logic              r_tok_vld;

    logic [31:0]       cap_prod;
    logic [13:0]       cap_q;
    logic [CAP_W-1:0]  cap_q5;
    logic [CAP_W-1:0]  cap_rem;
    logic [LIM_W-1:0]  n_limit;
    logic [CAP_W-1:0]  spare_rate;
    logic [LIM_W-1:0]  spare_kb;
    logic [VAL_W-1:0]  rank_val;
    logic              rank_mode;
    logic              match;
    t_tok              n_tok;
    logic [16:0]       kb_blocks;
    logic [RATE_W-1:0] n_rate;
    logic [KB_W:0]     kb_sum;

    // byte limit = capacity * 64 / 5, via capacity / 5 by reciprocal
    assign cap_prod = {16'd0, i_cap_data} * 32'd52429;
    assign cap_q    = cap_prod[31:18];
    assign cap_q5   = {cap_q, 2'b00} + {2'b00, cap_q};
    assign cap_rem  = i_cap_data - cap_q5;
    assign n_limit  = {cap_q, 6'd0} + {14'd0, limit_frac(cap_rem[2:0])};

    // spare figures of this slot
    assign spare_rate = ({5'd0, r_cap} > r_rate) ? (r_cap - r_rate[CAP_W-1:0]) : '0;
    assign spare_kb   = ({4'd0, r_limit} > r_kb) ? (r_limit - r_kb[LIM_W-1:0]) : '0;
    assign rank_mode  = (i_ctx.bmode == BAL_RATE) || (i_ctx.bmode == BAL_BYTES);
    assign rank_val   = (i_ctx.bmode == BAL_RATE) ? {4'd0, spare_rate} : spare_kb;
    assign match      = (i_node_id == i_ctx.node) &&
                        ({1'b0, i_index} < i_ctx.nlim);

    // candidate compare, earlier slot wins ties
    always_comb begin
        n_tok = i_tok;
        if (match) begin
            if (!i_tok.found) begin
                n_tok.found    = 1'b1;
                n_tok.best     = i_index;
                n_tok.best_val = rank_mode ? rank_val : '0;
                n_tok.best_sr  = spare_rate;
                n_tok.best_sk  = spare_kb;
            end else if (rank_mode && (rank_val > i_tok.best_val)) begin
                n_tok.best     = i_index;
                n_tok.best_val = rank_val;
                n_tok.best_sr  = spare_rate;
                n_tok.best_sk  = spare_kb;
            end
        end
    end

    // token stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (i_tok_vld) begin
            r_tok <= n_tok;
        end
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_vld = r_tok_vld;

    // tick: rate = (kbytes / 128) * 10
    assign kb_blocks = r_kb[KB_W-1:7];
    assign n_rate    = {1'b0, kb_blocks, 3'b000} + {3'b000, kb_blocks, 1'b0};
    assign kb_sum    = {1'b0, r_kb} + {{(KB_W+1-KB_ADD_W){1'b0}}, i_upd.kb};

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= '0;
            r_limit <= '0;
            r_kb    <= '0;
            r_rate  <= '0;
        end else begin
            if (i_cap_we) begin
                r_cap   <= i_cap_data;
                r_limit <= n_limit;
            end
            if (i_tick) begin
                r_rate <= n_rate;
                r_kb   <= '0;
            end else if (i_upd.vld && (i_upd.sel == i_index)) begin
                r_kb <= kb_sum[KB_W] ? {KB_W{1'b1}} : kb_sum[KB_W-1:0];
            end
        end
    end

endmodule

>>> rtl/multipath_link_selector_top.sv
// ----------------------------------------------------------------------------
// multipath_link_selector_top: per-packet path chooser over channel slots
// Packets walk a chain of slot cells that pick a candidate channel; the chosen
// slot's kbyte counter is charged on forward. Ticks refresh measured rates.
//
//   Channel   Dir  Handshake                     Payload
//   s_axis    in   tvalid/tready                 tdata: dest_node, packet_bytes
//                                                tuser: kind
//   m_axis    out  tvalid/tready                 tdata: forwarded, dropped,
//                                                       no_path, chosen_channel
//   cfg       in   wr_en (no wait)               index, data
//
// A packet's result passes, from its transfer on, through the context stage, which
// loads on that edge, then the 4 slot cells, the hold stage, the output register.
// One packet is in the chain at a time; the next is taken once its result is
// loaded into the output register, even while m_axis stalls; an m_axis stall
// that holds back that load also holds back the next packet. A tick gives no result.
// Reset (synchronous, active low) sets config defaults, clears flags and slot state.
// ----------------------------------------------------------------------------
module multipath_link_selector_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_axis
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [23:0]                   i_s_axis_tdata,  // [7:0] dest_node, [23:8] packet_bytes
    input  logic                          i_s_axis_tuser,  // [0] kind
    // m_axis
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // [0] forwarded, [1] dropped,
                                                           // [2] no_path, [4:3] chosen_channel
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [mls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mls_pkg::CFG_W-1:0]     i_cfg_data
);
    import mls_pkg::*;

    logic [1:0]          r_bal;
    logic [1:0]          r_drop;
    logic [CNT_W-1:0]    r_nch;
    logic [CFG_W-1:0]    r_map;

    t_ctx                r_ctx;
    logic [KB_ADD_W-1:0] r_kb_add;
    logic                r_go;
    logic                r_busy;

    t_tok                r_fin;
    logic                r_fin_vld;

    logic                r_out_vld;
    logic                r_out_fwd;
    logic                r_out_drop;
    logic                r_out_nopath;
    logic [CH_W-1:0]     r_out_ch;

    logic                s_xfer;
    logic                pkt_xfer;
    logic                tick_xfer;
    logic [CNT_W-1:0]    nlim;
    t_tok                w_tok [NUM_CHAN+1];
    logic [NUM_CHAN:0]   w_vld;
    logic                load;
    logic                pass;
    t_upd                upd;

    // input side
    assign o_s_axis_tready = !r_busy;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign pkt_xfer        = s_xfer && !i_s_axis_tuser;
    assign tick_xfer       = s_xfer && i_s_axis_tuser;
    assign nlim            = (r_nch > CNT_W'(SLOT_LIM)) ? CNT_W'(SLOT_LIM) : r_nch;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal  <= BAL_RATE;
            r_drop <= DROP_RATE;
            r_nch  <= '0;
            r_map  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BAL:  r_bal  <= i_cfg_data[1:0];
                REG_DROP: r_drop <= i_cfg_data[1:0];
                REG_NCH:  r_nch  <= i_cfg_data[CNT_W-1:0];
                REG_MAP:  r_map  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // packet context, launch into the chain
    always_ff @(posedge i_clk) begin
        if (pkt_xfer) begin
            r_ctx.node  <= i_s_axis_tdata[NODE_W-1:0];
            r_ctx.bmode <= r_bal;
            r_ctx.nlim  <= nlim;
            r_kb_add    <= i_s_axis_tdata[23 -: KB_ADD_W];
        end
        if (!i_rst_n) begin
            r_go   <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_go <= pkt_xfer;
            if (pkt_xfer) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
        end
    end

    // chain of slot cells
    assign w_tok[0] = '0;
    assign w_vld[0] = r_go;

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_cell
        mls_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (CH_W'(g)),
            .i_node_id  (r_map[NODE_W*g +: NODE_W]),
            .i_cap_we   (i_cfg_wr_en && (i_cfg_index == CFG_IDX_W'(REG_CAP0 + g))),
            .i_cap_data (i_cfg_data[CAP_W-1:0]),
            .i_ctx      (r_ctx),
            .i_tick     (tick_xfer),
            .i_upd      (upd),
            .i_tok      (w_tok[g]),
            .i_tok_vld  (w_vld[g]),
            .o_tok      (w_tok[g+1]),
            .o_tok_vld  (w_vld[g+1])
        );
    end

    // hold the final choice until the output register is free
    always_ff @(posedge i_clk) begin
        if (w_vld[NUM_CHAN]) begin
            r_fin <= w_tok[NUM_CHAN];
        end
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (w_vld[NUM_CHAN]) begin
            r_fin_vld <= 1'b1;
        end else if (load) begin
            r_fin_vld <= 1'b0;
        end
    end

    assign load = r_fin_vld && (!r_out_vld || i_m_axis_tready);

    // drop test on the chosen slot
    always_comb begin
        case (r_drop)
            DROP_RATE:  pass = (r_fin.best_sr != '0);
            DROP_BYTES: pass = (r_fin.best_sk != '0);
            default:    pass = 1'b1;
        endcase
    end

    // charge the chosen slot on forward
    assign upd.vld = load && r_fin.found && pass;
    assign upd.sel = r_fin.best;
    assign upd.kb  = r_kb_add;

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_fwd    <= r_fin.found && pass;
            r_out_drop   <= r_fin.found && !pass;
            r_out_nopath <= !r_fin.found;
            r_out_ch     <= r_fin.found ? r_fin.best : '0;
        end
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out_ch, r_out_nopath, r_out_drop, r_out_fwd};

`ifndef NO_ASSERTIONS
    // at most one packet in the chain or hold stage
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_vld, r_fin_vld}))
        else $error("more than one token in the selector chain");

    // a token in flight means the input side is closed
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_vld || (w_vld != '0)) |-> r_busy)
        else $error("token in flight while not busy");

    // result flags are mutually exclusive and no path reports slot zero
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($onehot({r_out_fwd, r_out_drop, r_out_nopath}) &&
                       (!r_out_nopath || (r_out_ch == '0))))
        else $error("inconsistent result flags");

    // a packet transfer launches into the first cell next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pkt_xfer |=> (r_go && r_busy))
        else $error("packet not launched");
`endif

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multipath link selector
// Packets and refresh ticks stream in on s_axis while both sides idle at
// random. A local path-choice model tracks the per-slot kbyte counters and
// measured rates, predicts each routing decision at its transfer, and the
// monitor compares every m_axis result field by field. Register settings
// change only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb;
    import mls_pkg::*;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam logic [1:0] BAL_UNUSED  = 2'd3;
    localparam logic [1:0] DROP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic               kind;
        logic [NODE_W-1:0]  node;
        logic [BYTES_W-1:0] nbytes;
    } t_path_req;

    typedef struct packed {
        logic            fwd;
        logic            drop;
        logic            no_path;
        logic [CH_W-1:0] chan;
    } t_route_result;

    // DUT-facing signals
    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [23:0]          s_data = '0;
    logic                 s_user = KIND_PACKET;
    logic                 m_ready = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    wire                  s_ready;
    wire                  m_valid;
    wire [7:0]            m_data;

    // Path-choice model: registers and per-slot state
    logic [1:0]         bal_mode = BAL_RATE;
    logic [1:0]         drop_mode = DROP_RATE;
    logic [CNT_W-1:0]   n_in_use = '0;
    logic [31:0]        node_map = '0;
    logic [CAP_W-1:0]   chan_cap [NUM_CHAN] = '{default: '0};
    logic [KB_W-1:0]    kb_used [NUM_CHAN] = '{default: '0};
    logic [RATE_W-1:0]  meas_rate [NUM_CHAN] = '{default: '0};

    t_path_req     pending_reqs[$];
    t_route_result expected_routes[$];
    t_path_req     in_flight;
    bit            calm = 1'b1;
    int unsigned   send_gap = 0;
    int unsigned   stall_left = 0;
    int unsigned   mismatches = 0;
    int unsigned   n_packets = 0, n_ticks = 0, n_fwd = 0, n_drop = 0, n_nopath = 0;
    int unsigned   n_settings = 0;

    multipath_link_selector_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned spare_rate(input int unsigned s);
        return (chan_cap[s] > meas_rate[s]) ? chan_cap[s] - meas_rate[s] : 0;
    endfunction

    // Byte limit per 0.1 s period: capacity * 1024 / 8 / 10 kbytes
    function automatic int unsigned spare_kb(input int unsigned s);
        int unsigned lim;
        lim = (int'(chan_cap[s]) * 64) / 5;
        return (lim > kb_used[s]) ? lim - kb_used[s] : 0;
    endfunction

    // Routing decision and state update for one accepted transfer
    function automatic void predict_request(input t_path_req req);
        t_route_result res;
        int unsigned   nslots, best, best_val, v, pass_test, sum;
        bit            found;
        if (req.kind == KIND_TICK) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                meas_rate[k] = RATE_W'((kb_used[k] / 128) * 10);
                kb_used[k] = '0;
            end
            n_ticks++;
            return;
        end
        n_packets++;
        nslots = (n_in_use < SLOT_LIM) ? n_in_use : SLOT_LIM;
        found = 1'b0;
        best = 0;
        best_val = 0;
        for (int s = 0; s < nslots; s++) begin
            if (node_map[8*s +: 8] != req.node) continue;
            if (!found) begin
                found = 1'b1;
                best = s;
                if (bal_mode != BAL_RATE && bal_mode != BAL_BYTES) break;
            end
            v = (bal_mode == BAL_RATE) ? spare_rate(s) : spare_kb(s);
            // strict compare: ties stay with the earlier slot
            if (v > best_val) begin
                best = s;
                best_val = v;
            end
        end
        res = '0;
        if (!found) begin
            res.no_path = 1'b1;
            n_nopath++;
        end else begin
            if (drop_mode == DROP_RATE)       pass_test = spare_rate(best);
            else if (drop_mode == DROP_BYTES) pass_test = spare_kb(best);
            else                              pass_test = 1;
            if (pass_test != 0) begin
                sum = kb_used[best] + req.nbytes / 1024;
                kb_used[best] = (sum > 24'hFFFFFF) ? 24'hFFFFFF : KB_W'(sum);
                n_fwd++;
            end else begin
                n_drop++;
            end
            res.fwd  = (pass_test != 0);
            res.drop = (pass_test == 0);
            res.chan = CH_W'(best);
        end
        expected_routes.insert(expected_routes.size(), res);
    endfunction

    // Compare one result transfer against the oldest prediction
    function automatic void check_route(input logic [7:0] bus);
        t_route_result got, want;
        got.fwd     = bus[0];
        got.drop    = bus[1];
        got.no_path = bus[2];
        got.chan    = bus[4:3];
        if (expected_routes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result with nothing expected:", $realtime,
                         " fwd=%0b drop=%0b no_path=%0b chan=%0d",
                         got.fwd, got.drop, got.no_path, got.chan);
            return;
        end
        want = expected_routes.pop_front();
        if (got.fwd !== want.fwd || got.drop !== want.drop ||
            got.no_path !== want.no_path || got.chan !== want.chan) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: route differs: expected fwd=%0b drop=%0b no_path=%0b chan=%0d,",
                         $realtime, want.fwd, want.drop, want.no_path, want.chan,
                         " got fwd=%0b drop=%0b no_path=%0b chan=%0d",
                         got.fwd, got.drop, got.no_path, got.chan);
        end
    endfunction

    // Driver: feeds queued requests with random gaps between transfers
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            s_data <= '0;
            s_user <= KIND_PACKET;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) predict_request(in_flight);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_flight = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_data <= {in_flight.nbytes, in_flight.node};
                    s_user <= in_flight.kind;
                    send_gap = idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, checks each result transfer
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) check_route(m_data);
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    task automatic push_req(input logic kind, input int unsigned node,
                            input int unsigned nbytes);
        t_path_req req;
        req.kind = kind;
        req.node = NODE_W'(node);
        req.nbytes = BYTES_W'(nbytes);
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    // Register write; the model copy follows at once since the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_BAL:  bal_mode = val[1:0];
            REG_DROP: drop_mode = val[1:0];
            REG_NCH:  n_in_use = val[CNT_W-1:0];
            REG_MAP:  node_map = val;
            default:  chan_cap[int'(idx) - REG_CAP0] = val[CAP_W-1:0];
        endcase
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Wait for all transfers and results, then let the pipeline empty
    task automatic settle_block();
        while (pending_reqs.size() != 0 || s_valid || expected_routes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: directed phases, then random register settings and traffic
    initial begin
        logic [7:0]  pool [3];
        logic [31:0] map;
        int unsigned r;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: no slots in use, so no path
        push_req(KIND_PACKET, 'h00, 0);
        settle_block();

        // first path, never drop; extremes of node and size
        cfg_write(REG_BAL, CFG_W'(BAL_FIRST));
        cfg_write(REG_DROP, CFG_W'(DROP_NEVER));
        cfg_write(REG_NCH, 4);
        cfg_write(REG_MAP, 32'h0707_FF00);
        cfg_write(CFG_IDX_W'(REG_CAP0 + 0), 0);
        cfg_write(CFG_IDX_W'(REG_CAP0 + 1), 'hFFFF);
        cfg_write(CFG_IDX_W'(REG_CAP0 + 2), 1);
        cfg_write(CFG_IDX_W'(REG_CAP0 + 3), 2);
        cfg_done();
        push_req(KIND_PACKET, 'h00, 0);
        push_req(KIND_PACKET, 'hFF, 'hFFFF);
        push_req(KIND_PACKET, 'h07, 1023);
        push_req(KIND_PACKET, 'h07, 1024);
        push_req(KIND_PACKET, 'h5A, 100);
        push_req(KIND_TICK, 'hFF, 'hFFFF);
        settle_block();

        // most spare kbytes: exhaust both small limits, then drop
        cfg_write(REG_BAL, CFG_W'(BAL_BYTES));
        cfg_write(REG_DROP, CFG_W'(DROP_BYTES));
        cfg_done();
        push_req(KIND_PACKET, 'h07, 'hFFFF);
        push_req(KIND_PACKET, 'h07, 'hFFFF);
        push_req(KIND_PACKET, 'h07, 'hFFFF);
        push_req(KIND_PACKET, 'h00, 1024);
        settle_block();

        // load slot 2 past 128 kbytes so the tick yields a nonzero rate
        cfg_write(REG_DROP, CFG_W'(DROP_NEVER));
        cfg_done();
        push_req(KIND_PACKET, 'h07, 'hFFFF);
        push_req(KIND_PACKET, 'h07, 'hFFFF);
        push_req(KIND_TICK, 0, 0);
        settle_block();

        // most spare rate; zero-capacity slot drops
        cfg_write(REG_BAL, CFG_W'(BAL_RATE));
        cfg_write(REG_DROP, CFG_W'(DROP_RATE));
        cfg_write(CFG_IDX_W'(REG_CAP0 + 2), 10);
        cfg_write(CFG_IDX_W'(REG_CAP0 + 3), 10);
        cfg_done();
        push_req(KIND_PACKET, 'h07, 2048);
        push_req(KIND_PACKET, 'hFF, 0);
        push_req(KIND_PACKET, 'h00, 0);
        settle_block();

        // equal spare rate on slots 2 and 3: earlier slot wins
        cfg_write(CFG_IDX_W'(REG_CAP0 + 2), 20);
        cfg_done();
        push_req(KIND_PACKET, 'h07, 0);
        settle_block();

        // unused mode codes, oversized slot count, all-ones map
        cfg_write(REG_BAL, CFG_W'(BAL_UNUSED));
        cfg_write(REG_DROP, CFG_W'(DROP_UNUSED));
        cfg_write(REG_NCH, 7);
        cfg_write(REG_MAP, 32'hFFFF_FFFF);
        cfg_done();
        push_req(KIND_PACKET, 'hFF, 'hFFFF);
        push_req(KIND_PACKET, 'h00, 'h8000);
        push_req(KIND_TICK, 'h00, 0);
        settle_block();

        // random phases
        for (int phase = 0; phase < 10; phase++) begin
            calm = (phase == 4);
            cfg_write(REG_BAL, $urandom_range(0, 3));
            cfg_write(REG_DROP, $urandom_range(0, 3));
            r = $urandom_range(0, 9);
            if (r == 0)      cfg_write(REG_NCH, 0);
            else if (r == 1) cfg_write(REG_NCH, $urandom_range(5, 7));
            else             cfg_write(REG_NCH, $urandom_range(1, 4));
            // a few node ids shared among slots so candidates compete
            foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 9);
            if (r == 0)      map = $urandom();
            else if (r == 1) map = '1;
            else for (int k = 0; k < 4; k++) map[8*k +: 8] = pool[$urandom_range(0, 2)];
            cfg_write(REG_MAP, map);
            for (int k = 0; k < NUM_CHAN; k++) begin
                r = $urandom_range(0, 9);
                if (r < 2)      cfg_write(CFG_IDX_W'(REG_CAP0 + k), 0);
                else if (r < 4) cfg_write(CFG_IDX_W'(REG_CAP0 + k), 'hFFFF);
                else if (r < 8) cfg_write(CFG_IDX_W'(REG_CAP0 + k), $urandom_range(1, 40));
                else            cfg_write(CFG_IDX_W'(REG_CAP0 + k), $urandom_range(0, 65535));
            end
            cfg_done();
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_req(KIND_TICK, $urandom_range(0, 255), $urandom_range(0, 65535));
                end else begin
                    r = $urandom_range(0, 4);
                    push_req(KIND_PACKET,
                             ($urandom_range(0, 4) != 0) ? node_map[8*$urandom_range(0, 3) +: 8]
                                                         : $urandom_range(0, 255),
                             (r < 2) ? $urandom_range(0, 65535) :
                             (r < 4) ? $urandom_range(49152, 65535) : $urandom_range(0, 2047));
                end
            end
            settle_block();
        end

        $display("Routed %0d packets: %0d forwarded, %0d dropped, %0d with no path.",
                 n_packets, n_fwd, n_drop, n_nopath);
        $display("Applied %0d refresh ticks across %0d register settings.", n_ticks, n_settings);
        if (mismatches == 0 && expected_routes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d result mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("Timed out with %0d results outstanding", expected_routes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
